// File: rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define CR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define CR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cr_pkg.sv
package cr_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int PARAM_FRAC_DEF  = 16;

   localparam int TEN_W     = 16;
   localparam logic [TEN_W-1:0] TEN_RESET = 16'd128;
   localparam logic NORM_RESET = 1'b1;

   // chord difference times 128
   localparam int TAN_SHIFT = 7;
   // extra bits for basis weights
   localparam int CC_EXTRA  = 3;

   // normal magnitudes are brought below 2^30 before the length
   localparam int NRM_BITS   = 30;
   localparam int SQRT_W     = 31;
   localparam int UNIT_SHIFT = 16;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic REG_TENSION   = 1'b0;
   localparam logic REG_NORMALISE = 1'b1;

endpackage

// File: rtl/cr_div.sv
module cr_div #(
   parameter int LANES = 1,
   parameter int NUM_W = 8,
   parameter int DEN_W = 8,
   parameter int SB_W  = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [LANES*NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0]       den_in,
   input  logic [SB_W-1:0]        sb_in,
   output logic                   out_valid,
   output logic [LANES*NUM_W-1:0] quot_out,
   output logic [SB_W-1:0]        sb_out
);

   logic [NUM_W-1:0]       valid_ff;
   logic [LANES*NUM_W-1:0] acc_ff   [NUM_W];
   logic [LANES*DEN_W-1:0] rem_ff   [NUM_W];
   logic [DEN_W-1:0]       den_ff   [NUM_W];
   logic [SB_W-1:0]        sb_ff    [NUM_W];
   logic [LANES*NUM_W-1:0] acc_prev [NUM_W];
   logic [LANES*DEN_W-1:0] rem_prev [NUM_W];
   logic [DEN_W-1:0]       den_prev [NUM_W];
   logic [SB_W-1:0]        sb_prev  [NUM_W];
   logic [LANES*NUM_W-1:0] acc_in   [NUM_W];
   logic [LANES*DEN_W-1:0] rem_in   [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_prev
      if (s == 0) begin : g_first
         assign acc_prev[s] = num_in;
         assign rem_prev[s] = '0;
         assign den_prev[s] = den_in;
         assign sb_prev[s]  = sb_in;
      end else begin : g_next
         assign acc_prev[s] = acc_ff[s-1];
         assign rem_prev[s] = rem_ff[s-1];
         assign den_prev[s] = den_ff[s-1];
         assign sb_prev[s]  = sb_ff[s-1];
      end
   end

   // one quotient bit per stage, restoring
   always_comb begin
      logic [DEN_W:0]   trial;
      logic [NUM_W-1:0] acc;
      for (int s = 0; s < NUM_W; s++) begin
         for (int l = 0; l < LANES; l++) begin
            acc   = acc_prev[s][l*NUM_W +: NUM_W];
            trial = {rem_prev[s][l*DEN_W +: DEN_W], acc[NUM_W-1]};
            if (trial >= {1'b0, den_prev[s]}) begin
               rem_in[s][l*DEN_W +: DEN_W] = DEN_W'(trial - {1'b0, den_prev[s]});
               acc_in[s][l*NUM_W +: NUM_W] = {acc[NUM_W-2:0], 1'b1};
            end else begin
               rem_in[s][l*DEN_W +: DEN_W] = trial[DEN_W-1:0];
               acc_in[s][l*NUM_W +: NUM_W] = {acc[NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NUM_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NUM_W; s++) begin
            acc_ff[s] <= acc_in[s];
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_prev[s];
            sb_ff[s]  <= sb_prev[s];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign quot_out  = acc_ff[NUM_W-1];
   assign sb_out    = sb_ff[NUM_W-1];

endmodule

// File: rtl/cr_sqrt.sv
module cr_sqrt #(
   parameter int OUT_W = 8,
   parameter int SB_W  = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [2*OUT_W-1:0] val_in,
   input  logic [SB_W-1:0]    sb_in,
   output logic               out_valid,
   output logic [OUT_W-1:0]   root_out,
   output logic [SB_W-1:0]    sb_out
);

   localparam int RM_W = OUT_W + 1;

   logic [OUT_W-1:0]   valid_ff;
   logic [2*OUT_W-1:0] val_ff    [OUT_W];
   logic [RM_W-1:0]    rem_ff    [OUT_W];
   logic [OUT_W-1:0]   root_ff   [OUT_W];
   logic [SB_W-1:0]    sb_ff     [OUT_W];
   logic [2*OUT_W-1:0] val_prev  [OUT_W];
   logic [RM_W-1:0]    rem_prev  [OUT_W];
   logic [OUT_W-1:0]   root_prev [OUT_W];
   logic [SB_W-1:0]    sb_prev   [OUT_W];
   logic [RM_W-1:0]    rem_in    [OUT_W];
   logic [OUT_W-1:0]   root_in   [OUT_W];

   for (genvar s = 0; s < OUT_W; s++) begin : g_prev
      if (s == 0) begin : g_first
         assign val_prev[s]  = val_in;
         assign rem_prev[s]  = '0;
         assign root_prev[s] = '0;
         assign sb_prev[s]   = sb_in;
      end else begin : g_next
         assign val_prev[s]  = val_ff[s-1];
         assign rem_prev[s]  = rem_ff[s-1];
         assign root_prev[s] = root_ff[s-1];
         assign sb_prev[s]   = sb_ff[s-1];
      end
   end

   // one root bit per stage
   always_comb begin
      logic [RM_W+1:0] trial;
      logic [RM_W+1:0] sub;
      for (int s = 0; s < OUT_W; s++) begin
         trial = {rem_prev[s], val_prev[s][2*OUT_W-1 -: 2]};
         sub   = (RM_W+2)'({root_prev[s], 2'b01});
         if (trial >= sub) begin
            rem_in[s]  = RM_W'(trial - sub);
            root_in[s] = {root_prev[s][OUT_W-2:0], 1'b1};
         end else begin
            rem_in[s]  = RM_W'(trial);
            root_in[s] = {root_prev[s][OUT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[OUT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < OUT_W; s++) begin
            val_ff[s]  <= {val_prev[s][2*OUT_W-3:0], 2'b00};
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            sb_ff[s]   <= sb_prev[s];
         end
      end
   end

   assign out_valid = valid_ff[OUT_W-1];
   assign root_out  = root_ff[OUT_W-1];
   assign sb_out    = sb_ff[OUT_W-1];

endmodule

// File: rtl/catmull_rom_point_and_normal.sv
// Catmull-Rom segment evaluator: takes four control points and t per word and returns the
// curve point and its normal, optionally scaled to unit length, all saturated to Q16.16.
// Fully pipelined: one word per cycle in and out unless rsp_stall holds the pipe, through
// the bit-per-stage tangent divider (COORD_WIDTH + 8 stages), the bit-per-stage square
// root of the normal length (31 stages), the bit-per-stage unit-scale divider (46 stages)
// and ten single register stages. Tension and normalise_enable are written over the APB
// port while no word is in flight; this binds the user, the block does not enforce it.
module catmull_rom_point_and_normal #(
   parameter int COORD_WIDTH     = cr_pkg::COORD_WIDTH_DEF,
   parameter int PARAM_FRAC_BITS = cr_pkg::PARAM_FRAC_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [COORD_WIDTH-1:0]      req_pa_x,
   input  logic signed [COORD_WIDTH-1:0]      req_pa_y,
   input  logic signed [COORD_WIDTH-1:0]      req_pb_x,
   input  logic signed [COORD_WIDTH-1:0]      req_pb_y,
   input  logic signed [COORD_WIDTH-1:0]      req_pc_x,
   input  logic signed [COORD_WIDTH-1:0]      req_pc_y,
   input  logic signed [COORD_WIDTH-1:0]      req_pd_x,
   input  logic signed [COORD_WIDTH-1:0]      req_pd_y,
   input  logic [PARAM_FRAC_BITS:0]           req_param_t,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [COORD_WIDTH-1:0]      rsp_point_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_point_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_norm_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_norm_y,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cr_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cr_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cr_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                               pready
);
   import cr_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int F      = PARAM_FRAC_BITS;
   localparam int TP_W   = F + 1;
   localparam int TSQ_W  = 2 * TP_W;
   localparam int DF_W   = CW + 1;
   localparam int NUM_W  = DF_W + TAN_SHIFT;
   localparam int TW     = NUM_W + 1;
   localparam int CC_W   = F + CC_EXTRA;
   localparam int MP_W   = CC_W + TW;
   localparam int PW     = MP_W + 2;
   localparam int RW     = PW - F;
   localparam int SH_W   = $clog2(RW + 1);
   localparam int NUM2_W = NRM_BITS + UNIT_SHIFT;
   localparam int HALF   = 1 << (F - 1);
   localparam logic [TP_W-1:0] T_ONE = TP_W'(1) << F;

   typedef struct packed {
      logic signed [CW-1:0]   bx, by, cx, cy;
      logic signed [DF_W-1:0] ex, ey;
      logic signed [CC_W-1:0] c0, c1, c2, c3, d0, d1, d2;
      logic [3:0]             neg;
   } tan_sb_type;

   typedef struct packed {
      logic signed [CW-1:0] px, py;
      logic signed [RW-1:0] nx, ny;
   } res_type;

   typedef struct packed {
      res_type             res;
      logic [NRM_BITS-1:0] ax, ay;
   } sq_sb_type;

   typedef struct packed {
      res_type res;
      logic    nz;
   } dv_sb_type;

   function automatic logic signed [CW-1:0] sat_rw(input logic signed [RW-1:0] v);
      if (&v[RW-1:CW-1] || ~|v[RW-1:CW-1])
         sat_rw = v[CW-1:0];
      else if (v[RW-1])
         sat_rw = {1'b1, {(CW-1){1'b0}}};
      else
         sat_rw = {1'b0, {(CW-1){1'b1}}};
   endfunction

   // registers
   logic [TEN_W-1:0] tension_ff;
   logic             norm_en_ff;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= TEN_RESET;
         norm_en_ff <= NORM_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_TENSION:   tension_ff <= pwdata[TEN_W-1:0];
            REG_NORMALISE: norm_en_ff <= pwdata[0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TENSION:   prdata = {{(CSR_DATA_W-TEN_W){1'b0}}, tension_ff};
         REG_NORMALISE: prdata = {{(CSR_DATA_W-1){1'b0}}, norm_en_ff};
         default:       prdata = '0;
      endcase
   end

   // pipeline advance
   logic adv;
   logic last_valid;
   logic rsp_valid_ff;

   assign adv       = !last_valid || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: clamp t, square, chord differences
   logic                   s1_valid_ff;
   logic [TP_W-1:0]        s1_t_ff;
   logic [TSQ_W-1:0]       s1_tsq_ff;
   logic signed [CW-1:0]   s1_pt_ff [4];
   logic signed [DF_W-1:0] s1_df_ff [4];
   logic signed [DF_W-1:0] s1_e_ff  [2];
   logic [TP_W-1:0]        t_c;

   assign t_c = (req_param_t > T_ONE) ? T_ONE : req_param_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_t_ff     <= t_c;
         s1_tsq_ff   <= TSQ_W'(t_c) * TSQ_W'(t_c);
         s1_pt_ff[0] <= req_pb_x;
         s1_pt_ff[1] <= req_pb_y;
         s1_pt_ff[2] <= req_pc_x;
         s1_pt_ff[3] <= req_pc_y;
         s1_df_ff[0] <= DF_W'(req_pc_x) - DF_W'(req_pa_x);
         s1_df_ff[1] <= DF_W'(req_pc_y) - DF_W'(req_pa_y);
         s1_df_ff[2] <= DF_W'(req_pd_x) - DF_W'(req_pb_x);
         s1_df_ff[3] <= DF_W'(req_pd_y) - DF_W'(req_pb_y);
         s1_e_ff[0]  <= DF_W'(req_pb_x) - DF_W'(req_pc_x);
         s1_e_ff[1]  <= DF_W'(req_pb_y) - DF_W'(req_pc_y);
      end
   end

   // stage 2: t^2, t^3 product, tangent numerators
   logic                   s2_valid_ff;
   logic [TP_W-1:0]        s2_t_ff;
   logic [TP_W-1:0]        s2_t2_ff;
   logic [TSQ_W-1:0]       s2_t3p_ff;
   logic signed [CW-1:0]   s2_pt_ff [4];
   logic signed [DF_W-1:0] s2_e_ff  [2];
   logic [NUM_W-1:0]       s2_mag_ff [4];
   logic [3:0]             s2_neg_ff;
   logic [TP_W-1:0]        t2_c;
   logic [DF_W-1:0]        df_abs [4];

   assign t2_c = TP_W'((s1_tsq_ff + TSQ_W'(HALF)) >> F);

   always_comb begin
      for (int l = 0; l < 4; l++)
         df_abs[l] = s1_df_ff[l][DF_W-1] ? DF_W'(-s1_df_ff[l]) : DF_W'(s1_df_ff[l]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_t_ff   <= s1_t_ff;
         s2_t2_ff  <= t2_c;
         s2_t3p_ff <= TSQ_W'(t2_c) * TSQ_W'(s1_t_ff);
         s2_pt_ff  <= s1_pt_ff;
         s2_e_ff   <= s1_e_ff;
         for (int l = 0; l < 4; l++) begin
            s2_mag_ff[l] <= {df_abs[l], {TAN_SHIFT{1'b0}}};
            s2_neg_ff[l] <= s1_df_ff[l][DF_W-1];
         end
      end
   end

   // basis weights
   logic [TP_W-1:0]        t3_c;
   logic signed [CC_W-1:0] q1, q2, q3, q_one;
   tan_sb_type             tan_sb_in, tan_sb_out;
   logic [TEN_W-1:0]       ten_val;
   logic [4*NUM_W-1:0]     tan_num, tan_q;
   logic                   tan_valid;

   assign t3_c  = TP_W'((s2_t3p_ff + TSQ_W'(HALF)) >> F);
   assign q1    = $signed(CC_W'(s2_t_ff));
   assign q2    = $signed(CC_W'(s2_t2_ff));
   assign q3    = $signed(CC_W'(t3_c));
   assign q_one = $signed(CC_W'(T_ONE));

   always_comb begin
      tan_sb_in.bx  = s2_pt_ff[0];
      tan_sb_in.by  = s2_pt_ff[1];
      tan_sb_in.cx  = s2_pt_ff[2];
      tan_sb_in.cy  = s2_pt_ff[3];
      tan_sb_in.ex  = s2_e_ff[0];
      tan_sb_in.ey  = s2_e_ff[1];
      tan_sb_in.c0  = CC_W'(2 * q3 - 3 * q2 + q_one);
      tan_sb_in.c1  = CC_W'(q3 - 2 * q2 + q1);
      tan_sb_in.c2  = CC_W'(3 * q2 - 2 * q3);
      tan_sb_in.c3  = CC_W'(q3 - q2);
      tan_sb_in.d0  = CC_W'(3 * q2 - 4 * q1 + q_one);
      tan_sb_in.d1  = CC_W'(3 * q2 - 2 * q1);
      tan_sb_in.d2  = CC_W'(6 * q2 - 6 * q1);
      tan_sb_in.neg = s2_neg_ff;
      for (int l = 0; l < 4; l++)
         tan_num[l*NUM_W +: NUM_W] = s2_mag_ff[l];
   end

   // zero tension acts as one
   assign ten_val = (tension_ff == '0) ? TEN_W'(1) : tension_ff;

   cr_div #(
      .LANES (4),
      .NUM_W (NUM_W),
      .DEN_W (TEN_W),
      .SB_W  ($bits(tan_sb_type))
   ) u_tan_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s2_valid_ff),
      .num_in    (tan_num),
      .den_in    (ten_val),
      .sb_in     (tan_sb_in),
      .out_valid (tan_valid),
      .quot_out  (tan_q),
      .sb_out    (tan_sb_out)
   );

   // signed tangents: v1x, v1y, v2x, v2y
   logic signed [TW-1:0] tan_v [4];

   always_comb begin
      for (int l = 0; l < 4; l++)
         tan_v[l] = tan_sb_out.neg[l] ? -$signed({1'b0, tan_q[l*NUM_W +: NUM_W]})
                                      :  $signed({1'b0, tan_q[l*NUM_W +: NUM_W]});
   end

   // products
   logic                   m_valid_ff;
   logic signed [MP_W-1:0] m_prod_ff [14];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= tan_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_prod_ff[0]  <= MP_W'(tan_sb_out.c0) * MP_W'(tan_sb_out.bx);
         m_prod_ff[1]  <= MP_W'(tan_sb_out.c1) * MP_W'(tan_v[0]);
         m_prod_ff[2]  <= MP_W'(tan_sb_out.c2) * MP_W'(tan_sb_out.cx);
         m_prod_ff[3]  <= MP_W'(tan_sb_out.c3) * MP_W'(tan_v[2]);
         m_prod_ff[4]  <= MP_W'(tan_sb_out.c0) * MP_W'(tan_sb_out.by);
         m_prod_ff[5]  <= MP_W'(tan_sb_out.c1) * MP_W'(tan_v[1]);
         m_prod_ff[6]  <= MP_W'(tan_sb_out.c2) * MP_W'(tan_sb_out.cy);
         m_prod_ff[7]  <= MP_W'(tan_sb_out.c3) * MP_W'(tan_v[3]);
         m_prod_ff[8]  <= MP_W'(tan_sb_out.d0) * MP_W'(tan_v[1]);
         m_prod_ff[9]  <= MP_W'(tan_sb_out.d1) * MP_W'(tan_v[3]);
         m_prod_ff[10] <= MP_W'(tan_sb_out.d2) * MP_W'(tan_sb_out.ey);
         m_prod_ff[11] <= MP_W'(tan_sb_out.d0) * MP_W'(tan_v[0]);
         m_prod_ff[12] <= MP_W'(tan_sb_out.d1) * MP_W'(tan_v[2]);
         m_prod_ff[13] <= MP_W'(tan_sb_out.d2) * MP_W'(tan_sb_out.ex);
      end
   end

   // weighted sums
   logic                 a_valid_ff;
   logic signed [PW-1:0] a_sum_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_sum_ff[0] <= PW'(m_prod_ff[0]) + PW'(m_prod_ff[1])
                      + PW'(m_prod_ff[2]) + PW'(m_prod_ff[3]);
         a_sum_ff[1] <= PW'(m_prod_ff[4]) + PW'(m_prod_ff[5])
                      + PW'(m_prod_ff[6]) + PW'(m_prod_ff[7]);
         a_sum_ff[2] <= PW'(m_prod_ff[8]) + PW'(m_prod_ff[9]) + PW'(m_prod_ff[10]);
         a_sum_ff[3] <= PW'(m_prod_ff[11]) + PW'(m_prod_ff[12]) + PW'(m_prod_ff[13]);
      end
   end

   // round half up to Q16.16
   logic                 r_valid_ff;
   logic signed [RW-1:0] r_val_ff [4];
   logic signed [RW-1:0] rnd [4];

   always_comb begin
      for (int i = 0; i < 4; i++)
         rnd[i] = RW'((a_sum_ff[i] + PW'(HALF)) >>> F);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (adv) begin
         r_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_val_ff[0] <= rnd[0];
         r_val_ff[1] <= rnd[1];
         r_val_ff[2] <= rnd[2];
         r_val_ff[3] <= -rnd[3];
      end
   end

   // normal magnitudes
   logic          n1_valid_ff;
   res_type       n1_res_ff;
   logic [RW-1:0] n1_ax_ff, n1_ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_valid_ff <= 1'b0;
      end else if (adv) begin
         n1_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_res_ff.px <= sat_rw(r_val_ff[0]);
         n1_res_ff.py <= sat_rw(r_val_ff[1]);
         n1_res_ff.nx <= r_val_ff[2];
         n1_res_ff.ny <= r_val_ff[3];
         n1_ax_ff     <= r_val_ff[2][RW-1] ? RW'(-r_val_ff[2]) : RW'(r_val_ff[2]);
         n1_ay_ff     <= r_val_ff[3][RW-1] ? RW'(-r_val_ff[3]) : RW'(r_val_ff[3]);
      end
   end

   // shift count to bring both below 2^30
   logic            n2_valid_ff;
   res_type         n2_res_ff;
   logic [RW-1:0]   n2_ax_ff, n2_ay_ff;
   logic [SH_W-1:0] n2_sh_ff;
   logic [RW-1:0]   n_or;
   logic [SH_W-1:0] n_blen;
   logic [SH_W-1:0] n_sh;

   assign n_or = n1_ax_ff | n1_ay_ff;

   always_comb begin
      n_blen = '0;
      for (int i = 0; i < RW; i++)
         if (n_or[i])
            n_blen = SH_W'(i + 1);
      n_sh = (n_blen > SH_W'(NRM_BITS)) ? SH_W'(n_blen - SH_W'(NRM_BITS)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n2_valid_ff <= 1'b0;
      end else if (adv) begin
         n2_valid_ff <= n1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n2_res_ff <= n1_res_ff;
         n2_ax_ff  <= n1_ax_ff;
         n2_ay_ff  <= n1_ay_ff;
         n2_sh_ff  <= n_sh;
      end
   end

   // shifted magnitudes
   logic                n3_valid_ff;
   res_type             n3_res_ff;
   logic [NRM_BITS-1:0] n3_ax_ff, n3_ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n3_valid_ff <= 1'b0;
      end else if (adv) begin
         n3_valid_ff <= n2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n3_res_ff <= n2_res_ff;
         n3_ax_ff  <= NRM_BITS'(n2_ax_ff >> n2_sh_ff);
         n3_ay_ff  <= NRM_BITS'(n2_ay_ff >> n2_sh_ff);
      end
   end

   // squares
   logic                  n4_valid_ff;
   sq_sb_type             n4_sb_ff;
   logic [2*NRM_BITS-1:0] n4_sqx_ff, n4_sqy_ff;
   logic [2*SQRT_W-1:0]   sq_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         n4_valid_ff <= 1'b0;
      end else if (adv) begin
         n4_valid_ff <= n3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n4_sb_ff.res <= n3_res_ff;
         n4_sb_ff.ax  <= n3_ax_ff;
         n4_sb_ff.ay  <= n3_ay_ff;
         n4_sqx_ff    <= (2*NRM_BITS)'(n3_ax_ff) * (2*NRM_BITS)'(n3_ax_ff);
         n4_sqy_ff    <= (2*NRM_BITS)'(n3_ay_ff) * (2*NRM_BITS)'(n3_ay_ff);
      end
   end

   assign sq_sum = (2*SQRT_W)'(n4_sqx_ff) + (2*SQRT_W)'(n4_sqy_ff);

   logic              sq_valid;
   logic [SQRT_W-1:0] sq_root;
   sq_sb_type         sq_sb_out;

   cr_sqrt #(
      .OUT_W (SQRT_W),
      .SB_W  ($bits(sq_sb_type))
   ) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (n4_valid_ff),
      .val_in    (sq_sum),
      .sb_in     (n4_sb_ff),
      .out_valid (sq_valid),
      .root_out  (sq_root),
      .sb_out    (sq_sb_out)
   );

   dv_sb_type           dv_sb_in, dv_sb_out;
   logic [2*NUM2_W-1:0] dv_num, dv_q;

   assign dv_sb_in.res = sq_sb_out.res;
   assign dv_sb_in.nz  = (sq_root != '0);
   assign dv_num       = {sq_sb_out.ay, {UNIT_SHIFT{1'b0}}, sq_sb_out.ax, {UNIT_SHIFT{1'b0}}};

   cr_div #(
      .LANES (2),
      .NUM_W (NUM2_W),
      .DEN_W (SQRT_W),
      .SB_W  ($bits(dv_sb_type))
   ) u_unit_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .num_in    (dv_num),
      .den_in    (sq_root),
      .sb_in     (dv_sb_in),
      .out_valid (last_valid),
      .quot_out  (dv_q),
      .sb_out    (dv_sb_out)
   );

   // unit normal select and output word
   logic signed [RW-1:0] ux, uy, nx_f, ny_f;
   logic signed [CW-1:0] point_x_ff, point_y_ff, norm_x_ff, norm_y_ff;

   assign ux = $signed(RW'(dv_q[0 +: UNIT_SHIFT+1]));
   assign uy = $signed(RW'(dv_q[NUM2_W +: UNIT_SHIFT+1]));

   always_comb begin
      if (norm_en_ff && dv_sb_out.nz) begin
         nx_f = dv_sb_out.res.nx[RW-1] ? -ux : ux;
         ny_f = dv_sb_out.res.ny[RW-1] ? -uy : uy;
      end else begin
         nx_f = dv_sb_out.res.nx;
         ny_f = dv_sb_out.res.ny;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         point_x_ff <= dv_sb_out.res.px;
         point_y_ff <= dv_sb_out.res.py;
         norm_x_ff  <= sat_rw(nx_f);
         norm_y_ff  <= sat_rw(ny_f);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = point_x_ff;
   assign rsp_point_y = point_y_ff;
   assign rsp_norm_x  = norm_x_ff;
   assign rsp_norm_y  = norm_y_ff;

endmodule

// File: rtl/cr_checker.sv
`include "assert_macros.svh"

module cr_checker #(
   parameter int COORD_WIDTH = cr_pkg::COORD_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [COORD_WIDTH-1:0]        rsp_point_x,
   input logic                          psel,
   input logic                          penable,
   input logic                          pwrite,
   input logic                          pready,
   input logic [cr_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [cr_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [cr_pkg::CSR_DATA_W-1:0] prdata
);
   import cr_pkg::*;

   logic             ten_wr;
   logic             ten_seen_ff;
   logic [TEN_W-1:0] ten_last_ff;
   logic             ten_chk;
   logic             rsp_held;

   assign ten_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TENSION);

   always_ff @(posedge clock) begin
      if (reset) begin
         ten_seen_ff <= 1'b0;
      end else begin
         ten_seen_ff <= ten_wr;
      end
   end

   always_ff @(posedge clock) begin
      ten_last_ff <= pwdata[TEN_W-1:0];
   end

   assign ten_chk  = ten_seen_ff && (paddr[2] == REG_TENSION);
   assign rsp_held = rsp_valid && rsp_stall;

   `CR_ASSERT(a_pready_high, clock, reset, pready, "pready dropped")
   `CR_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_held, rsp_valid, "stalled word lost")
   `CR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_held, $stable(rsp_point_x), "stalled word changed")
   `CR_ASSERT_IMPL(a_ten_readback, clock, reset, ten_chk, prdata[TEN_W-1:0] == ten_last_ff, "tension readback")

endmodule

bind catmull_rom_point_and_normal cr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_point_x (rsp_point_x),
   .psel        (psel),
   .penable     (penable),
   .pwrite      (pwrite),
   .pready      (pready),
   .paddr       (paddr),
   .pwdata      (pwdata),
   .prdata      (prdata)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import cr_pkg::*;

   localparam int CW = 32;
   localparam int PF = 16;
   localparam longint S = 64'sd1 <<< PF;
   localparam int LATENCY = 250;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct {
      coord_type ax, ay, bx, by, cx, cy, dx, dy;
      logic [PF:0] t;
   } word_type;
   typedef struct {
      coord_type px, py, nx, ny;
   } curve_type;
   typedef struct {
      word_type w;
      bit typed;
      curve_type want;
   } row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_type req_pa_x = '0, req_pa_y = '0, req_pb_x = '0, req_pb_y = '0;
   coord_type req_pc_x = '0, req_pc_y = '0, req_pd_x = '0, req_pd_y = '0;
   logic [PF:0] req_param_t = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   coord_type rsp_point_x, rsp_point_y, rsp_norm_x, rsp_norm_y;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   logic [TEN_W-1:0] cfg_tension = TEN_RESET;
   logic cfg_normalise = NORM_RESET;
   curve_type expected_curve[$];
   bit failed = 0;
   int send_idle_pct = 37;
   int recv_idle_pct = 37;
   int results_seen = 0;
   int hold_left = 0;
   bit hold_done = 0;

   catmull_rom_point_and_normal DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pa_x(req_pa_x), .req_pa_y(req_pa_y), .req_pb_x(req_pb_x), .req_pb_y(req_pb_y),
      .req_pc_x(req_pc_x), .req_pc_y(req_pc_y), .req_pd_x(req_pd_x), .req_pd_y(req_pd_y),
      .req_param_t(req_param_t),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #2_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic coord_type saturate(longint v);
      if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (v < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
      return coord_type'(v);
   endfunction

   function automatic longint round_q16(longint v);
      return (v + (64'sd1 <<< (PF - 1))) >>> PF;
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic curve_type eval_curve(word_type w);
      longint t, t2, t3, ten, c0, c1, c2, c3, d0, d1, d2;
      longint v1x, v1y, v2x, v2y, px, py, nx, ny;
      longint unsigned mx, my, len;
      curve_type r;
      ten = (cfg_tension == 0) ? 1 : longint'(cfg_tension);
      t = (w.t > S) ? S : longint'(w.t);
      t2 = (t * t + S / 2) >>> PF;
      t3 = (t2 * t + S / 2) >>> PF;
      v1x = ((longint'(w.cx) - longint'(w.ax)) * 128) / ten;
      v1y = ((longint'(w.cy) - longint'(w.ay)) * 128) / ten;
      v2x = ((longint'(w.dx) - longint'(w.bx)) * 128) / ten;
      v2y = ((longint'(w.dy) - longint'(w.by)) * 128) / ten;
      c0 = 2 * t3 - 3 * t2 + S;
      c1 = t3 - 2 * t2 + t;
      c2 = 3 * t2 - 2 * t3;
      c3 = t3 - t2;
      px = round_q16(c0 * w.bx + c1 * v1x + c2 * w.cx + c3 * v2x);
      py = round_q16(c0 * w.by + c1 * v1y + c2 * w.cy + c3 * v2y);
      d0 = 3 * t2 - 4 * t + S;
      d1 = 3 * t2 - 2 * t;
      d2 = 6 * t2 - 6 * t;
      nx = round_q16(d0 * v1y + d1 * v2y + d2 * w.by - d2 * w.cy);
      ny = -round_q16(d0 * v1x + d1 * v2x + d2 * w.bx - d2 * w.cx);
      if (cfg_normalise && (nx != 0 || ny != 0)) begin
         mx = (nx < 0) ? -nx : nx;
         my = (ny < 0) ? -ny : ny;
         while (mx >= (64'd1 << 30) || my >= (64'd1 << 30)) begin
            mx >>= 1;
            my >>= 1;
         end
         len = int_root(mx * mx + my * my);
         if (len != 0) begin
            mx = (mx << 16) / len;
            my = (my << 16) / len;
            nx = (nx < 0) ? -longint'(mx) : longint'(mx);
            ny = (ny < 0) ? -longint'(my) : longint'(my);
         end
      end
      r.px = saturate(px);
      r.py = saturate(py);
      r.nx = saturate(nx);
      r.ny = saturate(ny);
      return r;
   endfunction

   task automatic check_field(string name, coord_type want, coord_type got);
      if (want !== got) begin
         $error("%s expected %0d got %0d", name, want, got);
         failed = 1;
      end
   endtask

   always @(posedge clock) begin
      curve_type e;
      if (reset === 1'b0 && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (expected_curve.size() == 0) begin
            $error("result word with nothing expected");
            failed = 1;
         end else begin
            e = expected_curve.pop_front();
            check_field("point_x", e.px, rsp_point_x);
            check_field("point_y", e.py, rsp_point_y);
            check_field("norm_x", e.nx, rsp_norm_x);
            check_field("norm_y", e.ny, rsp_norm_y);
         end
      end
   end

   // receiver stalls, with one long hold-off so the pipe backs up
   always @(posedge clock) begin
      if (reset !== 1'b0) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (!hold_done && results_seen >= 300) begin
            hold_left <= 600;
            hold_done <= 1;
         end
      end
   end

   task automatic send_word(word_type w, bit typed = 0, curve_type want = '{default: 0});
      req_pa_x <= w.ax;
      req_pa_y <= w.ay;
      req_pb_x <= w.bx;
      req_pb_y <= w.by;
      req_pc_x <= w.cx;
      req_pc_y <= w.cy;
      req_pd_x <= w.dx;
      req_pd_y <= w.dy;
      req_param_t <= w.t;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_curve.push_back(typed ? want : eval_curve(w));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic idx, logic [CSR_DATA_W-1:0] val);
      logic [CSR_DATA_W-1:0] want;
      want = (idx == REG_TENSION) ? CSR_DATA_W'(val[TEN_W-1:0]) : CSR_DATA_W'(val[0]);
      paddr <= {idx, 2'b00};
      pwdata <= val;
      pwrite <= 1'b1;
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want) begin
         $error("csr readback expected %0h got %0h", want, prdata);
         failed = 1;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      if (idx == REG_TENSION) cfg_tension = val[TEN_W-1:0];
      else cfg_normalise = val[0];
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_curve.size() != 0) @(posedge clock);
   endtask

   function automatic coord_type rand_coord(int kind);
      case (kind)
         0: return coord_type'($urandom_range(0, 1 << 21)) - (1 <<< 20);
         1: return coord_type'($urandom);
         default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      endcase
   endfunction

   function automatic word_type rand_word();
      word_type w;
      int pick, kind;
      pick = $urandom_range(99);
      kind = (pick < 60) ? 0 : (pick < 85) ? 1 : 2;
      w.ax = rand_coord(kind);
      w.ay = rand_coord(kind);
      w.bx = rand_coord(kind);
      w.by = rand_coord(kind);
      w.cx = rand_coord(kind);
      w.cy = rand_coord(kind);
      w.dx = rand_coord(kind);
      w.dy = rand_coord(kind);
      if (pick >= 90 && pick < 95) begin
         w.ay = w.ax;
         w.bx = w.ax;
         w.by = w.ax;
         w.cx = w.ax;
         w.cy = w.ax;
         w.dx = w.ax;
         w.dy = w.ax;
      end
      pick = $urandom_range(99);
      if (pick < 80) w.t = $urandom_range(0, 65536);
      else if (pick < 90) w.t = $urandom_range(1) ? 17'd65536 : 17'd0;
      else w.t = $urandom_range(65537, 131071);
      return w;
   endfunction

   function automatic word_type flat_word(coord_type x, coord_type y, logic [PF:0] t);
      word_type w;
      w.ax = x;
      w.bx = x;
      w.cx = x;
      w.dx = x;
      w.ay = y;
      w.by = y;
      w.cy = y;
      w.dy = y;
      w.t = t;
      return w;
   endfunction

   function automatic row_type mk_row(word_type w, bit typed, coord_type px = 0,
                                      coord_type py = 0);
      row_type r;
      r.w = w;
      r.typed = typed;
      r.want = '{px: px, py: py, nx: 0, ny: 0};
      return r;
   endfunction

   initial begin
      row_type rows[$];
      word_type w;
      logic [TEN_W-1:0] ten_set[8];
      bit norm_set[8];

      rows.push_back(mk_row(flat_word(0, 0, 0), 1));
      rows.push_back(mk_row(flat_word(32'sh10000, 32'sh20000, 0), 1, 32'sh10000, 32'sh20000));
      rows.push_back(mk_row(flat_word(32'sh30000, 32'sh40000, 17'd65536), 1,
                            32'sh30000, 32'sh40000));
      rows.push_back(mk_row(flat_word(32'sh30000, -32'sh40000, 17'd131071), 1,
                            32'sh30000, -32'sh40000));
      rows.push_back(mk_row(flat_word(32'sh7fffffff, 32'sh7fffffff, 17'd32768), 1,
                            32'sh7fffffff, 32'sh7fffffff));
      rows.push_back(mk_row(flat_word(32'sh80000000, 32'sh80000000, 17'd32768), 1,
                            32'sh80000000, 32'sh80000000));
      w = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
            32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 17'd32768};
      rows.push_back(mk_row(w, 0));
      w = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
            32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 17'd16384};
      rows.push_back(mk_row(w, 0));
      foreach (ten_set[i]) begin
         w = '{-32'sh10000, 0, 0, 0, 32'sh10000, 0, 32'sh20000, 32'sh8000, 17'd0};
         w.t = (i == 0) ? 17'd0 : (i == 1) ? 17'd1 : (i == 2) ? 17'd16384 :
               (i == 3) ? 17'd32768 : (i == 4) ? 17'd65535 : (i == 5) ? 17'd65536 :
               (i == 6) ? 17'd65537 : 17'd131071;
         rows.push_back(mk_row(w, 0));
      end
      w = '{32'sh12345, -32'sh6789a, 32'sh55555, 32'sh2aaaa, -32'sh33333, 32'sh11111,
            32'sh7654, -32'sh4321, 17'd40000};
      rows.push_back(mk_row(w, 0));

      ten_set = '{16'd128, 16'd1, 16'd65535, 16'd0, 16'd256, 16'd128, 16'd1, 16'd65535};
      norm_set = '{1, 0, 1, 1, 0, 0, 1, 0};
      ten_set[5] = $urandom_range(1, 65535);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
      drain();

      foreach (ten_set[p]) begin
         csr_write(REG_TENSION, CSR_DATA_W'(ten_set[p]));
         csr_write(REG_NORMALISE, CSR_DATA_W'(norm_set[p]));
         send_idle_pct = (p == 2) ? 0 : 37;
         recv_idle_pct = (p == 2) ? 0 : 37;
         repeat (217) send_word(rand_word());
         drain();
      end

      repeat (LATENCY) @(posedge clock);
      if (failed == 0 && expected_curve.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
